// File: hw/rtl/mst_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the minimum spanning tree unit.
// No dependencies.
package mst_pkg;
  localparam int END_BITS = 6;   // vertex number field width
  localparam int CFG_BITS = 7;   // vertex_count register width
  localparam int CMP_BITS = 12;  // width for vertex range compares
endpackage

// File: hw/rtl/mst_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: edge input, tree output, config write.
// Depends on mst_pkg.
interface mst_in_if import mst_pkg::*; #(parameter int WEIGHT_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [END_BITS-1:0]           edge_src;
  logic [END_BITS-1:0]           edge_dst;
  logic signed [WEIGHT_BITS-1:0] edge_weight;
  logic                          last_edge;
  modport source (output valid, edge_src, edge_dst, edge_weight, last_edge, input ready);
  modport sink (input valid, edge_src, edge_dst, edge_weight, last_edge, output ready);
endinterface

interface mst_out_if import mst_pkg::*; #(parameter int WEIGHT_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [END_BITS-1:0]           tree_src;
  logic [END_BITS-1:0]           tree_dst;
  logic signed [WEIGHT_BITS-1:0] tree_weight;
  logic                          last_result;
  logic                          empty_tree;
  modport source (output valid, tree_src, tree_dst, tree_weight, last_result, empty_tree,
                  input ready);
  modport sink (input valid, tree_src, tree_dst, tree_weight, last_result, empty_tree,
                output ready);
endinterface

interface mst_cfg_if import mst_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/mst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mst_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/minimum_spanning_tree_unit.sv
`timescale 1ns / 1ps
// Kruskal minimum spanning forest: edge load, insertion sort, union-find scan.
// Depends on mst_pkg, mst_if, mst_ram.
//
//  channel | dir | transfer when      | payload
//  in_if   | in  | valid && ready    | edge_src, edge_dst, edge_weight, last_edge
//  out_if  | out | valid && ready    | tree_src, tree_dst, tree_weight, last_result, empty_tree
//  cfg_if  | in  | valid (ready = 1) | data = vertex_count
//
// Edges load one per cycle. After the last edge each vertex is made its own parent in the parent
// memory, then the insertion sort reads each edge's weight, walks down the sorted list shifting
// heavier entries up, and puts the edge in. Scan: each sorted edge is read; an in-range edge walks
// to the roots of both ends, a joined edge links them and is queued; at the end the final result is queued.
// Input is held off until the run's last result sits in the output register.
// Reset is synchronous; a stalled output holds the scan.
module minimum_spanning_tree_unit import mst_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  mst_in_if.sink    in_if,
  mst_out_if.source out_if,
  mst_cfg_if.sink   cfg_if
);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int EW  = 2 * END_BITS + WEIGHT_BITS;
  localparam int SW  = WEIGHT_BITS + EAW;
  localparam logic [CMP_BITS-1:0] MAXV_C = CMP_BITS'(MAX_VERTICES);

  typedef enum logic [12:0] {
    S_LOAD = 13'b0000000000001,
    S_CLR  = 13'b0000000000010,
    S_SI   = 13'b0000000000100,
    S_SW   = 13'b0000000001000,
    S_SC   = 13'b0000000010000,
    S_SPUT = 13'b0000000100000,
    S_KRD  = 13'b0000001000000,
    S_KWS  = 13'b0000010000000,
    S_KWE  = 13'b0000100000000,
    S_KFA  = 13'b0001000000000,
    S_KFB  = 13'b0010000000000,
    S_KEM  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ECW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [VAW-1:0] cv_r, cv_nxt, x_r, x_nxt, ra_r, ra_nxt;
  logic signed [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [END_BITS-1:0] cur_src_r, cur_src_nxt, cur_dst_r, cur_dst_nxt;
  logic [WEIGHT_BITS-1:0] cur_wt_r, cur_wt_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [END_BITS-1:0] pend_src_r, pend_src_nxt, pend_dst_r, pend_dst_nxt;
  logic [WEIGHT_BITS-1:0] pend_wt_r, pend_wt_nxt;
  logic out_v_r, out_v_nxt, out_last_r, out_last_nxt, out_empty_r, out_empty_nxt;
  logic [END_BITS-1:0] out_src_r, out_src_nxt, out_dst_r, out_dst_nxt;
  logic [WEIGHT_BITS-1:0] out_wt_r, out_wt_nxt;
  logic [CFG_BITS-1:0] vc_r, vc_nxt;

  logic e_we, s_we, p_we;
  logic [EAW-1:0] e_wa, e_ra, s_wa, s_ra;
  logic [EW-1:0] e_wd, e_rd;
  logic [SW-1:0] s_wd, s_rd;
  logic [VAW-1:0] p_wa, p_wd, p_ra, p_rd;

  logic ofree, in_xfer;
  logic [ECW-1:0] jm1, jm2;
  logic [CMP_BITS-1:0] vcl;
  logic [END_BITS-1:0] rd_src, rd_dst;

  mst_ram #(.W(EW), .D(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  mst_ram #(.W(SW), .D(MAX_EDGES)) u_sort_ram (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  mst_ram #(.W(VAW), .D(MAX_VERTICES)) u_parent_ram (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  assign in_if.ready        = (state_r == S_LOAD);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_v_r;
  assign out_if.tree_src    = out_src_r;
  assign out_if.tree_dst    = out_dst_r;
  assign out_if.tree_weight = out_wt_r;
  assign out_if.last_result = out_last_r;
  assign out_if.empty_tree  = out_empty_r;

  assign in_xfer = in_if.valid && (state_r == S_LOAD);
  assign ofree   = !out_v_r || out_if.ready;
  assign jm1     = j_r - ECW'(1);
  assign jm2     = j_r - ECW'(2);
  assign vcl     = (CMP_BITS'(vc_r) > MAXV_C) ? MAXV_C : CMP_BITS'(vc_r);
  assign rd_src  = e_rd[EW-1 -: END_BITS];
  assign rd_dst  = e_rd[EW-END_BITS-1 -: END_BITS];

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    cv_nxt = cv_r; x_nxt = x_r; ra_nxt = ra_r; w_nxt = w_r;
    cur_src_nxt = cur_src_r; cur_dst_nxt = cur_dst_r; cur_wt_nxt = cur_wt_r;
    pend_v_nxt = pend_v_r; pend_src_nxt = pend_src_r;
    pend_dst_nxt = pend_dst_r; pend_wt_nxt = pend_wt_r;
    out_v_nxt = out_v_r; out_src_nxt = out_src_r; out_dst_nxt = out_dst_r;
    out_wt_nxt = out_wt_r; out_last_nxt = out_last_r; out_empty_nxt = out_empty_r;
    vc_nxt = cfg_if.valid ? cfg_if.data : vc_r;
    e_we = 1'b0; e_wa = n_r[EAW-1:0];
    e_wd = {in_if.edge_src, in_if.edge_dst, in_if.edge_weight};
    e_ra = i_r[EAW-1:0];
    s_we = 1'b0; s_wa = j_r[EAW-1:0]; s_wd = s_rd; s_ra = jm1[EAW-1:0];
    p_we = 1'b0; p_wa = cv_r; p_wd = cv_r; p_ra = x_r;
    if (out_v_r && out_if.ready) begin
      out_v_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (n_r < ECW'(MAX_EDGES)) begin
            e_we  = 1'b1;
            n_nxt = n_r + ECW'(1);
          end
          if (in_if.last_edge) begin
            cv_nxt    = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        p_we   = 1'b1;
        cv_nxt = cv_r + VAW'(1);
        if (cv_r == VAW'(MAX_VERTICES - 1)) begin
          i_nxt     = '0;
          state_nxt = S_SI;
        end
      end
      S_SI: begin
        if (i_r == n_r) begin
          k_nxt     = '0;
          state_nxt = S_KRD;
        end else begin
          j_nxt     = i_r;
          state_nxt = S_SW;
        end
      end
      S_SW: begin
        w_nxt     = $signed(e_rd[WEIGHT_BITS-1:0]);
        state_nxt = (j_r == '0) ? S_SPUT : S_SC;
      end
      S_SC: begin
        if ($signed(s_rd[SW-1 -: WEIGHT_BITS]) > w_r) begin
          s_we  = 1'b1;
          j_nxt = jm1;
          s_ra  = jm2[EAW-1:0];
          if (jm1 == '0) begin
            state_nxt = S_SPUT;
          end
        end else begin
          state_nxt = S_SPUT;
        end
      end
      S_SPUT: begin
        s_we      = 1'b1;
        s_wd      = {w_r, i_r[EAW-1:0]};
        i_nxt     = i_r + ECW'(1);
        state_nxt = S_SI;
      end
      S_KRD: begin
        s_ra = k_r[EAW-1:0];
        state_nxt = (k_r == n_r) ? S_FIN : S_KWS;
      end
      S_KWS: begin
        e_ra      = s_rd[EAW-1:0];
        state_nxt = S_KWE;
      end
      S_KWE: begin
        cur_src_nxt = rd_src;
        cur_dst_nxt = rd_dst;
        cur_wt_nxt  = e_rd[WEIGHT_BITS-1:0];
        if (CMP_BITS'(rd_src) >= vcl || CMP_BITS'(rd_dst) >= vcl) begin
          k_nxt     = k_r + ECW'(1);
          state_nxt = S_KRD;
        end else begin
          x_nxt     = VAW'(rd_src);
          p_ra      = VAW'(rd_src);
          state_nxt = S_KFA;
        end
      end
      S_KFA: begin
        if (p_rd == x_r) begin
          ra_nxt    = x_r;
          x_nxt     = VAW'(cur_dst_r);
          p_ra      = VAW'(cur_dst_r);
          state_nxt = S_KFB;
        end else begin
          x_nxt = p_rd;
          p_ra  = p_rd;
        end
      end
      S_KFB: begin
        if (p_rd == x_r) begin
          if (x_r == ra_r) begin
            k_nxt     = k_r + ECW'(1);
            state_nxt = S_KRD;
          end else begin
            p_we      = 1'b1;
            p_wa      = ra_r;
            p_wd      = x_r;
            state_nxt = S_KEM;
          end
        end else begin
          x_nxt = p_rd;
          p_ra  = p_rd;
        end
      end
      S_KEM: begin
        if (!pend_v_r || ofree) begin
          if (pend_v_r) begin
            out_v_nxt     = 1'b1;
            out_src_nxt   = pend_src_r;
            out_dst_nxt   = pend_dst_r;
            out_wt_nxt    = pend_wt_r;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_src_nxt = cur_src_r;
          pend_dst_nxt = cur_dst_r;
          pend_wt_nxt  = cur_wt_r;
          k_nxt        = k_r + ECW'(1);
          state_nxt    = S_KRD;
        end
      end
      S_FIN: begin
        if (ofree) begin
          out_v_nxt     = 1'b1;
          out_last_nxt  = 1'b1;
          out_empty_nxt = !pend_v_r;
          out_src_nxt   = pend_v_r ? pend_src_r : '0;
          out_dst_nxt   = pend_v_r ? pend_dst_r : '0;
          out_wt_nxt    = pend_v_r ? pend_wt_r : '0;
          pend_v_nxt    = 1'b0;
          n_nxt         = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      n_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      vc_r     <= CFG_BITS'(64);
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      vc_r     <= vc_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    cv_r <= cv_nxt; x_r <= x_nxt; ra_r <= ra_nxt; w_r <= w_nxt;
    cur_src_r <= cur_src_nxt; cur_dst_r <= cur_dst_nxt; cur_wt_r <= cur_wt_nxt;
    pend_src_r <= pend_src_nxt; pend_dst_r <= pend_dst_nxt; pend_wt_r <= pend_wt_nxt;
    out_src_r <= out_src_nxt; out_dst_r <= out_dst_nxt; out_wt_r <= out_wt_nxt;
    out_last_r <= out_last_nxt; out_empty_r <= out_empty_nxt;
  end
endmodule

// File: hw/rtl/mst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for minimum_spanning_tree_unit, attached by bind.
// Depends on mst_pkg.
module mst_checker import mst_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [END_BITS-1:0]    out_src,
  input logic [END_BITS-1:0]    out_dst,
  input logic [WEIGHT_BITS-1:0] out_wt,
  input logic                   out_last,
  input logic                   out_empty
);
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted during a run");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && out_src == '0 && out_dst == '0 && out_wt == '0)
    else $error("malformed empty result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src) && $stable(out_dst)
      && $stable(out_wt) && $stable(out_last) && $stable(out_empty))
    else $error("stalled result changed");
endmodule

bind minimum_spanning_tree_unit mst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_mst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_last   (in_if.last_edge),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_src   (out_if.tree_src),
  .out_dst   (out_if.tree_dst),
  .out_wt    (out_if.tree_weight),
  .out_last  (out_if.last_result),
  .out_empty (out_if.empty_tree)
);

// File: verif/tb_minimum_spanning_tree_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for minimum_spanning_tree_unit: random graphs, Kruskal predictor.
// Depends on mst_pkg, mst_if and the unit itself.
module tb_minimum_spanning_tree_unit import mst_pkg::*;;

  typedef struct packed {
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] weight;
    logic        last;
  } edge_item_t;

  typedef struct packed {
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] weight;
    logic        last_result;
    logic        empty_tree;
  } tree_edge_t;

  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mst_in_if  #(.WEIGHT_BITS(16)) in_if();
  mst_out_if #(.WEIGHT_BITS(16)) out_if();
  mst_cfg_if cfg_if();

  minimum_spanning_tree_unit #(.MAX_VERTICES(64), .MAX_EDGES(256), .WEIGHT_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  edge_item_t edge_queue[$];
  tree_edge_t tree_expect[$];
  edge_item_t graph[$];
  int vertex_count = 64;
  int fail_count = 0;
  int cycle_count = 0;
  int out_holdoff = 0;
  bit feed_pause = 1'b0;
  bit in_took = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Kruskal: stable sort by signed weight, union-find over the effective vertex count.
  task automatic predict_forest();
    int order[$];
    int parent[64];
    int rnk[64];
    int vc, n, j, tmp, ra, rb, cnt;
    tree_edge_t t;
    vc = vertex_count > 64 ? 64 : vertex_count;
    n = graph.size() > 256 ? 256 : graph.size();
    for (int i = 0; i < 64; i++) begin
      parent[i] = i;
      rnk[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      order.push_back(i);
      j = i;
      while (j > 0 && $signed(graph[order[j-1]].weight) > $signed(graph[i].weight)) begin
        tmp = order[j-1]; order[j-1] = order[j]; order[j] = tmp;
        j--;
      end
    end
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      edge_item_t e;
      e = graph[order[i]];
      if (e.src >= vc || e.dst >= vc) continue;
      ra = e.src;
      while (parent[ra] != ra) ra = parent[ra];
      rb = e.dst;
      while (parent[rb] != rb) rb = parent[rb];
      if (ra == rb) continue;
      if (rnk[ra] < rnk[rb]) parent[ra] = rb;
      else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
      else begin
        parent[rb] = ra;
        rnk[ra]++;
      end
      t = '{src: e.src, dst: e.dst, weight: e.weight, last_result: 1'b0, empty_tree: 1'b0};
      tree_expect.push_back(t);
      cnt++;
    end
    if (cnt == 0) tree_expect.push_back('{6'd0, 6'd0, 16'd0, 1'b1, 1'b1});
    else tree_expect[tree_expect.size()-1].last_result = 1'b1;
    graph.delete();
  endtask

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (in_took) begin
      if (in_if.last_edge) predict_forest();
      in_gap = gap_len();
    end
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
    end else if (in_gap > 0 || feed_pause || edge_queue.size() == 0) begin
      if (in_gap > 0) in_gap--;
      in_if.valid <= 1'b0;
    end else begin
      edge_item_t e;
      e = edge_queue.pop_front();
      graph.push_back(e);
      in_if.valid <= 1'b1;
      in_if.edge_src <= e.src;
      in_if.edge_dst <= e.dst;
      in_if.edge_weight <= e.weight;
      in_if.last_edge <= e.last;
    end
  end

  // receiver ready
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_holdoff > 0) begin
      out_holdoff--;
      out_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    in_took = rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tree_expect.size() == 0) begin
        $error("unexpected tree edge %0d-%0d", out_if.tree_src, out_if.tree_dst);
        fail_count++;
      end else begin
        tree_edge_t x;
        x = tree_expect.pop_front();
        if (out_if.tree_src !== x.src) begin
          $error("tree_src exp %0d got %0d", x.src, out_if.tree_src); fail_count++;
        end
        if (out_if.tree_dst !== x.dst) begin
          $error("tree_dst exp %0d got %0d", x.dst, out_if.tree_dst); fail_count++;
        end
        if (out_if.tree_weight !== x.weight) begin
          $error("tree_weight exp %0d got %0d", $signed(x.weight), out_if.tree_weight);
          fail_count++;
        end
        if (out_if.last_result !== x.last_result) begin
          $error("last_result exp %0b got %0b", x.last_result, out_if.last_result);
          fail_count++;
        end
        if (out_if.empty_tree !== x.empty_tree) begin
          $error("empty_tree exp %0b got %0b", x.empty_tree, out_if.empty_tree);
          fail_count++;
        end
      end
    end
  end

  task automatic add_edge(int s, int d, int w, bit last);
    edge_item_t e;
    e.src = s[5:0];
    e.dst = d[5:0];
    e.weight = w[15:0];
    e.last = last;
    edge_queue.push_back(e);
  endtask

  task automatic wait_drained();
    while (edge_queue.size() != 0 || in_if.valid || tree_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vertex_count(int v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v[6:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    vertex_count = v;
  endtask

  task automatic random_graph(int vmax, int n);
    int w;
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 15) - 8;
      add_edge($urandom_range(0, vmax), $urandom_range(0, vmax), w, i == n - 1);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.edge_src = '0;
    in_if.edge_dst = '0;
    in_if.edge_weight = '0;
    in_if.last_edge = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, self loop, repeat, out of range
    add_edge(0, 63, -32768, 0);
    add_edge(63, 0, 32767, 0);
    add_edge(5, 5, 0, 0);
    add_edge(1, 2, 7, 0);
    add_edge(2, 1, 7, 0);
    add_edge(42, 21, -1, 0);
    add_edge(21, 42, 1, 1);
    wait_drained();
    add_edge(3, 3, 100, 1);
    wait_drained();
    write_vertex_count(0);
    add_edge(0, 1, 5, 1);
    wait_drained();
    write_vertex_count(127);
    add_edge(63, 62, 3, 0);
    add_edge(0, 62, 3, 1);
    wait_drained();
    write_vertex_count(1);
    add_edge(0, 0, 2, 0);
    add_edge(0, 1, 2, 1);
    wait_drained();
    write_vertex_count(4);
    add_edge(0, 1, 1, 0);
    add_edge(3, 4, -3, 0);
    add_edge(2, 3, 1, 0);
    add_edge(1, 2, 0, 1);
    wait_drained();

    // larger graph over all vertices
    write_vertex_count(64);
    random_graph(63, 30);
    wait_drained();

    // long receiver hold-off while edges stream in
    write_vertex_count(16);
    out_holdoff = 400;
    random_graph(20, 12);
    random_graph(15, 8);
    wait_drained();

    for (int k = 0; k < 10; k++) begin
      write_vertex_count($urandom_range(1, 80));
      feed_pause = ($urandom_range(0, 2) == 0);
      random_graph($urandom_range(1, 63), $urandom_range(1, 14));
      if (feed_pause) begin
        repeat (5) @(posedge clk);
        feed_pause = 1'b0;
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
